// ===== src/hfs_pkg.sv =====
// Shared constants, types and elaboration-time table builders for the frequency shifter.
`default_nettype none

package hfs_pkg;

  localparam int HFS_TAPS       = 63;
  localparam int HFS_SINE_DEPTH = 1024;

  localparam int SMP_W     = 24;
  localparam int SHIFT_W   = 15;
  localparam int COEF_W    = 18;
  localparam int SIN_MAG_W = 17;
  localparam int PHASE_W   = 32;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  localparam logic [PHASE_W-1:0] PHASE_SCALE_RESET = 32'd586406201;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // Q30 constants used by the table builders
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint TWO_OVER_PI_Q30  = 64'sd683565276;
  localparam longint BK_A0            = 64'sd450971566;
  localparam longint BK_A2            = 64'sd85899346;
  localparam longint SIN_MAG_MAX      = 64'sd131071;

  // register index = paddr[CFG_AW-1:2]
  typedef enum logic [CFG_AW-3:0] {
    REG_PHASE_SCALE = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    logic [SMP_W-1:0]   sample;
    logic [SHIFT_W-1:0] shift;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PM0,
    ST_PM1,
    ST_PM2,
    ST_PM3,
    ST_RND,
    ST_SAT,
    ST_FIN
  } core_state_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(w * pi/2 / 2^30) in Q30, Horner form of the order-13 Taylor series
  function automatic logic [63:0] quarter_sin(input logic [63:0] w);
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] r;
    th = (w * HALF_PI_Q30) >> 30;
    t2 = (th * th) >> 30;
    r  = Q30_ONE;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd156;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd110;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd72;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
    return (th * r) >> 30;
  endfunction

  function automatic longint turn_sin(input logic [31:0] p);
    logic [63:0] w;
    longint      v;
    w = {34'd0, p[29:0]};
    case (p[31:30])
      2'd0:    v = $signed(quarter_sin(w));
      2'd1:    v = $signed(quarter_sin(Q30_ONE - w));
      2'd2:    v = -$signed(quarter_sin(w));
      default: v = -$signed(quarter_sin(Q30_ONE - w));
    endcase
    return v;
  endfunction

  // shift right, truncating toward zero
  function automatic longint trunc_shr(input longint v, input int unsigned sh);
    longint r;
    if (v < 0) r = -((-v) >>> sh);
    else       r = v >>> sh;
    return r;
  endfunction

  // round half away from zero, 13 fractional bits dropped
  function automatic longint rnd13(input longint v);
    longint r;
    if (v >= 0) r = (v + 64'sd4096) >>> 13;
    else        r = -((-v + 64'sd4096) >>> 13);
    return r;
  endfunction

  // Blackman-windowed Hilbert tap k, Q1.17
  function automatic logic [COEF_W-1:0] hilbert_coef(input int taps, input int k);
    longint      n;
    longint      c1;
    longint      c2;
    longint      win;
    longint      mag;
    longint      ideal;
    logic [63:0] q;
    logic [31:0] p1;
    logic [31:0] p2;
    n = longint'(k) - longint'(taps >> 1);
    if (n[0] == 1'b0) return '0;
    q     = long_div(64'(k) << 32, 64'(taps - 1));
    p1    = q[31:0];
    p2    = {p1[30:0], 1'b0};
    c1    = turn_sin(p1 + 32'h4000_0000);
    c2    = turn_sin(p2 + 32'h4000_0000);
    win   = BK_A0 - trunc_shr(c1, 1) + trunc_shr(BK_A2 * c2, 30);
    mag   = $signed(long_div(TWO_OVER_PI_Q30, (n < 0) ? -n : n));
    ideal = (n < 0) ? -mag : mag;
    return COEF_W'(rnd13(trunc_shr(ideal * win, 30)));
  endfunction

  // quarter-wave sine magnitude, entry k of depth
  function automatic logic [SIN_MAG_W-1:0] sine_mag(input int depth, input int k);
    logic [63:0] w;
    longint      v;
    w = long_div(64'(k) << 30, 64'(depth));
    v = rnd13($signed(quarter_sin(w)));
    if (v > SIN_MAG_MAX) v = SIN_MAG_MAX;
    return SIN_MAG_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== src/hfs_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module hfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 63,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/hfs_sine_rom.sv =====
// Quarter-wave sine magnitude ROM with registered read.
`default_nettype none

module hfs_sine_rom import hfs_pkg::*; #(
  parameter int SINE_DEPTH = HFS_SINE_DEPTH,
  localparam int AW        = $clog2(SINE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic [AW-1:0]        addr,
  output logic      [SIN_MAG_W-1:0] data
);

  typedef logic [SIN_MAG_W-1:0] sin_tab_t [SINE_DEPTH + 1];

  function automatic sin_tab_t build_tab();
    sin_tab_t tb;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      tb[k] = sine_mag(SINE_DEPTH, k);
    end
    return tb;
  endfunction

  localparam sin_tab_t SIN_TAB = build_tab();

  always_ff @(posedge clk) begin
    data <= SIN_TAB[addr];
  end

endmodule

`default_nettype wire

// ===== src/hfs_core.sv =====
// Sequencer and datapath: history RAM sweep, shared MAC, oscillator and output mix.
`default_nettype none

module hfs_core import hfs_pkg::*; #(
  parameter int TAPS       = HFS_TAPS,
  parameter int SINE_DEPTH = HFS_SINE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire job_t               job,
  input  wire logic [PHASE_W-1:0] scale,
  output logic                    busy,
  output logic                    res_valid,
  output logic [SMP_W-1:0]        res,
  input  wire logic               res_take
);

  localparam int TAP_W   = $clog2(TAPS);
  localparam int HALF    = TAPS / 2;
  localparam int SIN_AW  = $clog2(SINE_DEPTH + 1);
  localparam int ACC_W   = SMP_W + COEF_W + $clog2(TAPS);
  localparam int IL_W    = 25;
  localparam int MUL_AW  = IL_W + 1;
  localparam int PROD_W  = MUL_AW + COEF_W;
  localparam int FULL_W  = ACC_W + 20;
  localparam int RND_SH  = 34;
  localparam int RND_W   = FULL_W - RND_SH;
  localparam int PPROD_W = SHIFT_W + PHASE_W + 1;
  localparam int IMUL_W  = 30 + SIN_AW;

  // sweep steps at which the oscillator lookups happen
  localparam logic [TAP_W-1:0] T_IDX = TAP_W'(1);
  localparam logic [TAP_W-1:0] T_SIN = TAP_W'(3);
  localparam logic [TAP_W-1:0] T_COS = TAP_W'(4);

  localparam logic [TAP_W-1:0]         LAST_TAP = TAP_W'(TAPS - 1);
  localparam logic [TAP_W-1:0]         MID_TAP  = TAP_W'(HALF);
  localparam logic [FULL_W-1:0]        RND_BIAS = FULL_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [RND_W-1:0]  SAT_HI   = RND_W'(OUT_MAX);
  localparam logic signed [RND_W-1:0]  SAT_LO   = RND_W'(OUT_MIN);

  typedef logic [COEF_W-1:0] hrom_t [TAPS];

  function automatic hrom_t build_hrom();
    hrom_t r;
    for (int k = 0; k < TAPS; k++) begin
      r[k] = hilbert_coef(TAPS, k);
    end
    return r;
  endfunction

  localparam hrom_t HROM = build_hrom();

  core_state_t state_r, state_nxt;

  logic [TAP_W-1:0]          pos_r;
  logic [TAP_W-1:0]          addr_r;
  logic [TAP_W-1:0]          t_r;
  logic [TAP_W-1:0]          t1_r;
  logic [TAPS-1:0]           valid_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      drain_r;
  logic [PHASE_W-1:0]        phase_r;
  logic signed [PPROD_W-1:0] pprod;
  logic signed [PPROD_W-1:0] pprod_r;
  logic                      hv_r;
  logic signed [COEF_W-1:0]  coef_r;
  logic [SMP_W-1:0]          rdata;
  logic signed [SMP_W-1:0]   hist;
  logic signed [SMP_W-1:0]   real_r;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [FULL_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [FULL_W-1:0]  full_r;
  logic [FULL_W-1:0]         rsum;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [SMP_W-1:0]   sat;
  logic [SMP_W-1:0]          res_r;
  logic [IMUL_W-1:0]         imul;
  logic [SIN_AW-1:0]         i_r;
  logic [SIN_AW-1:0]         i_cmp;
  logic [SIN_AW-1:0]         rom_addr;
  logic [SIN_MAG_W-1:0]      sin_mag;
  logic signed [COEF_W-1:0]  s_r;
  logic signed [COEF_W-1:0]  c_r;
  logic [1:0]                quad;
  logic                      load_job;
  logic                      take_job;

  assign take_job = (state_r == ST_IDLE) && in_valid;
  assign load_job = take_job && (job.shift != '0);

  hfs_ram #(
    .WIDTH (SMP_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (load_job),
    .waddr (pos_r),
    .wdata (job.sample),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // oscillator table: sine address at step 2, cosine address at T_SIN
  assign quad     = phase_r[PHASE_W-1 -: 2];
  assign imul     = phase_r[29:0] * SIN_AW'(SINE_DEPTH);
  assign i_cmp    = SIN_AW'(SINE_DEPTH) - i_r;
  assign rom_addr = (t_r == T_SIN) ? (quad[0] ? i_r : i_cmp) : (quad[0] ? i_cmp : i_r);

  hfs_sine_rom #(
    .SINE_DEPTH (SINE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (sin_mag)
  );

  assign pprod    = $signed(job.shift) * $signed({1'b0, scale});
  assign hist     = hv_r ? $signed(rdata) : '0;
  assign prod_ext = FULL_W'(prod_r);
  assign rsum     = full_r + RND_BIAS - {{(FULL_W-1){1'b0}}, full_r[FULL_W-1]};

  always_comb begin
    case (state_r)
      ST_PM0: begin
        mul_a = MUL_AW'(real_r);
        mul_b = c_r;
      end
      ST_PM1: begin
        mul_a = $signed({1'b0, acc_r[IL_W-1:0]});
        mul_b = s_r;
      end
      ST_PM2: begin
        mul_a = MUL_AW'($signed(acc_r[ACC_W-1:IL_W]));
        mul_b = s_r;
      end
      default: begin
        mul_a = MUL_AW'(hist);
        mul_b = coef_r;
      end
    endcase
  end

  always_comb begin
    if (rnd_r > SAT_HI)      sat = SMP_W'(SAT_HI);
    else if (rnd_r < SAT_LO) sat = SMP_W'(SAT_LO);
    else                     sat = rnd_r[SMP_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = (job.shift == '0) ? ST_FIN : ST_MAC;
      ST_MAC:   if (t_r == LAST_TAP) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r) state_nxt = ST_PM0;
      ST_PM0:   state_nxt = ST_PM1;
      ST_PM1:   state_nxt = ST_PM2;
      ST_PM2:   state_nxt = ST_PM3;
      ST_PM3:   state_nxt = ST_RND;
      ST_RND:   state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_FIN;
      ST_FIN:   if (res_take) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      addr_r  <= '0;
      t_r     <= '0;
      valid_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      drain_r <= 1'b0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_MAC);
      v2_r    <= v1_r;
      drain_r <= (state_r == ST_DRAIN);
      if (load_job) begin
        valid_r[pos_r] <= 1'b1;
        pos_r          <= (pos_r == LAST_TAP) ? '0 : pos_r + 1'b1;
        addr_r         <= pos_r;
        t_r            <= '0;
      end else if (state_r == ST_MAC) begin
        addr_r <= (addr_r == '0) ? LAST_TAP : addr_r - 1'b1;
        t_r    <= t_r + 1'b1;
      end
      if ((state_r == ST_MAC) && (t_r == '0)) begin
        phase_r <= phase_r + pprod_r[16 +: PHASE_W];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    hv_r   <= valid_r[addr_r];
    coef_r <= $signed(HROM[t_r]);
    t1_r   <= t_r;
    prod_r <= mul_a * mul_b;

    if (take_job) begin
      pprod_r <= pprod;
      res_r   <= job.sample;
    end

    if (load_job)  acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + ACC_W'(prod_r);

    if (v1_r && (t1_r == MID_TAP)) real_r <= hist;

    if (state_r == ST_MAC) begin
      if (t_r == T_IDX) i_r <= imul[IMUL_W-1:30];
      if (t_r == T_SIN) s_r <= quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      if (t_r == T_COS) begin
        c_r <= (quad[1] ^ quad[0]) ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      end
    end

    case (state_r)
      ST_PM1: full_r <= prod_ext <<< 17;
      ST_PM2: full_r <= full_r - prod_ext;
      ST_PM3: full_r <= full_r - (prod_ext <<< IL_W);
      ST_RND: rnd_r  <= $signed(rsum[FULL_W-1:RND_SH]);
      ST_SAT: res_r  <= sat;
      default: ;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_FIN);
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== src/hilbert_frequency_shifter.sv =====
// Top level of the Hilbert-FIR single-sideband frequency shifter.
//
// Each input transaction carries one 24-bit audio sample and a signed shift in
// tenths of a hertz. The sample goes into a TAPS-deep history RAM; one shared
// multiply-accumulate unit then walks the RAM read port one tap per cycle to
// form the Hilbert (imaginary) branch against a constant windowed coefficient
// table, while a 32-bit phase accumulator steps by shift * phase_scale / 2^16
// and a quarter-wave sine ROM supplies sin and cos. The same multiplier then
// forms real*cos - imag*sin in three partial products, followed by rounding and
// 24-bit saturation. A non-zero shift is done once the one-tap-per-cycle sweep
// of the history RAM port and the product, rounding and saturation steps have
// run; a zero shift is a bypass that returns the sample unchanged and touches
// no state. One item is in flight at a time; the output register lets the next
// item start while a result waits. History entries read as zero until first
// written (valid bit per entry, reset clears them at once), so no clearing pass
// is needed. phase_scale lives at byte address 0 of the APB-style port; pready
// is always high.
`default_nettype none

module hilbert_frequency_shifter import hfs_pkg::*; #(
  parameter int TAPS       = HFS_TAPS,
  parameter int SINE_DEPTH = HFS_SINE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [SMP_W-1:0]   in_sample_in,
  input  wire logic signed [SHIFT_W-1:0] in_shift_tenths_hz,
  // result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [SMP_W-1:0]        out_sample_out,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [CFG_AW-1:0]         paddr,
  input  wire logic [CFG_DW-1:0]         pwdata,
  output logic [CFG_DW-1:0]              prdata,
  output logic                           pready
);

  logic [PHASE_W-1:0] scale_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  job_t               job;
  logic               busy;
  logic               res_valid;
  logic [SMP_W-1:0]   res;
  logic               res_take;

  logic               out_valid_r;
  logic [SMP_W-1:0]   out_sample_r;

  // config register: written on the APB access phase
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= PHASE_SCALE_RESET;
    end else if (cfg_wr && (cfg_sel == REG_PHASE_SCALE)) begin
      scale_r <= pwdata;
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PHASE_SCALE: prdata = scale_r;
      default:         prdata = '0;
    endcase
  end

  // input transaction goes straight to the core when it is idle
  assign job      = '{sample: in_sample_in, shift: in_shift_tenths_hz};
  assign in_stall = busy;

  hfs_core #(
    .TAPS       (TAPS),
    .SINE_DEPTH (SINE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .job       (job),
    .scale     (scale_r),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register: core hands over when the slot is empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_sample_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = $signed(out_sample_r);

endmodule

`default_nettype wire

// ===== tb/sv/hfs_shift_checker.sv =====
// Scoreboard for the frequency shifter: bit-exact predictor plus result comparison.
module hfs_shift_checker import hfs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [SMP_W-1:0]   in_sample_in,
  input  logic signed [SHIFT_W-1:0] in_shift_tenths_hz,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [SMP_W-1:0]   out_sample_out,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [CFG_DW-1:0]         pwdata,
  input  logic                      pready,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q30_UNIT    = 64'd1073741824;
  localparam longint unsigned QUARTER_PI2 = 64'd1686629713;  // pi/2 in Q30
  localparam longint          INV_PI2     = 64'sd683565276;  // 2/pi in Q30
  localparam longint          WIN_A0      = 64'sd450971566;
  localparam longint          WIN_A2      = 64'sd85899346;
  localparam int              PRINT_CAP   = 40;

  int                      sine_quarter [HFS_SINE_DEPTH+1];
  logic signed [COEF_W-1:0] hilbert_taps [HFS_TAPS];

  // shifter state mirror
  logic signed [SMP_W-1:0] audio_ring [HFS_TAPS];
  int                      ring_pos;
  logic [PHASE_W-1:0]      osc_phase;
  logic [PHASE_W-1:0]      osc_scale;

  logic signed [SMP_W-1:0] expected_samples [$];

  function automatic longint round_half_away(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // sin(w * pi/2 / 2^30) in Q30, truncating Horner evaluation of the Taylor series
  function automatic longint unsigned q30_quarter_sine(input longint unsigned w);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned acc;
    int unsigned     k;
    th  = (w * QUARTER_PI2) >> 30;
    th2 = (th * th) >> 30;
    acc = Q30_UNIT;
    for (k = 12; k >= 2; k -= 2)
      acc = Q30_UNIT - ((th2 * acc) >> 30) / longint'(k * (k + 1));
    return (th * acc) >> 30;
  endfunction

  function automatic longint q30_turn_sine(input logic [31:0] p);
    longint unsigned w;
    w = {34'd0, p[29:0]};
    case (p[31:30])
      2'd0:    return longint'(q30_quarter_sine(w));
      2'd1:    return longint'(q30_quarter_sine(Q30_UNIT - w));
      2'd2:    return -longint'(q30_quarter_sine(w));
      default: return -longint'(q30_quarter_sine(Q30_UNIT - w));
    endcase
  endfunction

  initial begin : build_tables
    int          k;
    longint      v;
    longint      n;
    longint      c1;
    longint      c2;
    longint      win;
    longint      ideal;
    logic [31:0] p1;
    for (k = 0; k <= HFS_SINE_DEPTH; k++) begin
      v = round_half_away(longint'(q30_quarter_sine((64'(k) << 30) / HFS_SINE_DEPTH)), 13);
      sine_quarter[k] = int'((v > 131071) ? 131071 : v);
    end
    for (k = 0; k < HFS_TAPS; k++) begin
      n = longint'(k) - longint'(HFS_TAPS / 2);
      if (n % 2 == 0) begin
        hilbert_taps[k] = '0;
      end else begin
        p1    = 32'((64'(k) << 32) / (HFS_TAPS - 1));
        c1    = q30_turn_sine(p1 + 32'h4000_0000);
        c2    = q30_turn_sine((p1 << 1) + 32'h4000_0000);
        win   = WIN_A0 - c1 / 2 + (WIN_A2 * c2) / longint'(Q30_UNIT);
        ideal = INV_PI2 / n;
        hilbert_taps[k] = COEF_W'(round_half_away((ideal * win) / longint'(Q30_UNIT), 13));
      end
    end
  end

  // Runs one transaction through the mirrored shifter, returns the output sample.
  function automatic logic signed [SMP_W-1:0] shift_sample(
    input logic signed [SMP_W-1:0]   smp,
    input logic signed [SHIFT_W-1:0] sh
  );
    longint real_part;
    longint imag_acc;
    longint prod;
    longint s;
    longint c;
    longint full;
    longint res;
    int     t;
    int     idx;
    if (sh == 0) return smp;  // bypass, state untouched
    audio_ring[ring_pos] = smp;
    real_part = audio_ring[(ring_pos + HFS_TAPS - HFS_TAPS / 2) % HFS_TAPS];
    imag_acc  = 0;
    for (t = 0; t < HFS_TAPS; t++)
      imag_acc += longint'(audio_ring[(ring_pos + HFS_TAPS - t) % HFS_TAPS])
                * longint'(hilbert_taps[t]);
    prod      = longint'(sh) * longint'({32'd0, osc_scale});
    osc_phase = osc_phase + 32'(prod >>> 16);  // floor, wraps mod 2^32
    idx       = int'(osc_phase[29:20]);
    case (osc_phase[31:30])
      2'd0: begin
        s = sine_quarter[idx];
        c = sine_quarter[HFS_SINE_DEPTH - idx];
      end
      2'd1: begin
        s = sine_quarter[HFS_SINE_DEPTH - idx];
        c = -sine_quarter[idx];
      end
      2'd2: begin
        s = -sine_quarter[idx];
        c = -sine_quarter[HFS_SINE_DEPTH - idx];
      end
      default: begin
        s = -sine_quarter[HFS_SINE_DEPTH - idx];
        c = sine_quarter[idx];
      end
    endcase
    full = real_part * c * 131072 - imag_acc * s;
    res  = round_half_away(full, 34);
    if (res > OUT_MAX) res = OUT_MAX;
    if (res < OUT_MIN) res = OUT_MIN;
    ring_pos = (ring_pos + 1) % HFS_TAPS;
    return SMP_W'(res);
  endfunction

  // printing stops after a while so a broken build doesn't flood the log
  task automatic flag_error(input string what, input logic signed [SMP_W-1:0] got,
                            input logic signed [SMP_W-1:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("ERROR %0t ns: %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic clear_state();
    int k;
    for (k = 0; k < HFS_TAPS; k++) audio_ring[k] = '0;
    ring_pos  = 0;
    osc_phase = '0;
    osc_scale = PHASE_SCALE_RESET;
    expected_samples.delete();
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    clear_state();
  end

  // Sample mid-cycle: inputs change only at the rising edge, so what holds here
  // is exactly what the next rising edge sees.
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_AW-1:2] == REG_PHASE_SCALE)
        osc_scale = pwdata;
      // pop before push so a stray result can't consume a fresh expectation
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0)
          flag_error("result with no transaction pending", out_sample_out, 'x);
        else if (out_sample_out !== expected_samples[0])
          flag_error("sample_out mismatch", out_sample_out, expected_samples.pop_front());
        else
          void'(expected_samples.pop_front());
      end
      if (in_valid && !in_stall)
        expected_samples.push_back(shift_sample(in_sample_in, in_shift_tenths_hz));
    end
    pending_count = expected_samples.size();
  end

endmodule

// ===== tb/sv/tb_hilbert_frequency_shifter.sv =====
// Testbench top: stimulus, flow control and verdict for the frequency shifter.
module tb_hilbert_frequency_shifter;
  import hfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Timeout: worst correct case is roughly 970 transactions, each with its gap,
  // processing latency and stall; allow several times that.
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int TAIL_CYCLES  = HFS_TAPS + 20;  // longer than the slowest result
  localparam int PHASE_ITEMS  = 135;            // random transactions per config setting
  localparam int LONG_HOLD    = 400;            // one receiver blackout, in cycles
  localparam int HOLD_TRIGGER = 300;            // after this many input transactions

  localparam logic [CFG_AW-1:0] ADDR_PHASE_SCALE = {REG_PHASE_SCALE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED    = {1'b1, 2'b00};  // no register behind it

  localparam logic signed [SMP_W-1:0]   SMP_MAX   = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0]   SMP_MIN   = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = {1'b0, {(SHIFT_W-1){1'b1}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                      in_valid           = 1'b0;
  logic                      in_stall;
  logic signed [SMP_W-1:0]   in_sample_in       = '0;
  logic signed [SHIFT_W-1:0] in_shift_tenths_hz = '0;

  // result channel
  logic                      out_valid;
  logic                      out_stall          = 1'b0;
  logic signed [SMP_W-1:0]   out_sample_out;

  // register port
  logic                      psel               = 1'b0;
  logic                      penable            = 1'b0;
  logic                      pwrite             = 1'b0;
  logic [CFG_AW-1:0]         paddr              = '0;
  logic [CFG_DW-1:0]         pwdata             = '0;
  logic [CFG_DW-1:0]         prdata;
  logic                      pready;

  int fail_count;
  int pending_count;
  int sent_count  = 0;  // accepted input transactions
  int burst_left  = 0;  // transactions still to send back to back
  int cycle_count = 0;

  always #6 clk = ~clk;

  hilbert_frequency_shifter dut (.*);

  hfs_shift_checker u_shift_check (.*);

  // Hard stop if the design hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Shift mix: bypass, tiny steps, the nominal +-1200 Hz span, and the raw 15-bit range.
  function automatic logic signed [SHIFT_W-1:0] pick_shift();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 22) return SHIFT_W'(int'($urandom_range(1, 20)) * ($urandom_range(0, 1) ? -1 : 1));
    if (r < 88) return SHIFT_W'(int'($urandom_range(0, 24000)) - 12000);
    return SHIFT_W'($urandom());
  endfunction

  // One input transaction. Stall is checked mid-cycle; the transfer happens at
  // the rising edge that follows a low stall.
  task automatic send_item(input logic signed [SMP_W-1:0] smp,
                           input logic signed [SHIFT_W-1:0] sh);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_sample_in <= SMP_W'($urandom());  // junk while idle
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample_in       <= smp;
    in_shift_tenths_hz <= sh;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent_count++;
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Setup + access phase; pready is tied high but honored anyway.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic in segments. Most segments keep one shift and feed
  // full-scale noise or square waves (square waves pile up the Hilbert sum and
  // drive the output into saturation); others hop the shift every sample.
  task automatic run_random(input int total);
    int                        done_cnt;
    int                        len;
    int                        kind;
    int                        half;
    int                        j;
    logic signed [SMP_W-1:0]   smp;
    logic signed [SHIFT_W-1:0] sh;
    done_cnt = 0;
    while (done_cnt < total) begin
      len  = $urandom_range(8, 48);
      kind = $urandom_range(0, 9);
      half = $urandom_range(1, 20);
      sh   = pick_shift();
      for (j = 0; j < len && done_cnt < total; j++) begin
        case (kind)
          0, 1, 2, 3: smp = SMP_W'($urandom());
          4, 5:       smp = ((j / half) % 2) ? SMP_MIN : SMP_MAX;
          6: begin
            smp = SMP_W'(int'($urandom_range(0, 510)) - 255);
            sh  = pick_shift();
          end
          7: begin
            smp = SMP_W'($urandom());
            sh  = pick_shift();
          end
          default: begin
            smp = SMP_W'($urandom());
            sh  = SHIFT_W'($urandom());
          end
        endcase
        send_item(smp, sh);
        done_cnt++;
      end
    end
  endtask

  // Receiver: random stall bursts, long free-running stretches, and one long
  // blackout mid-run so the shifter's output register fills and it stalls its input.
  initial begin : result_stall_gen
    int run_len;
    int hold_len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                            : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk);
      if (!long_hold_done && sent_count >= HOLD_TRIGGER) begin
        hold_len       = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold_len = idle_len();
      end
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, under the reset value of phase_scale:
    // bypass at both rails
    send_item(SMP_MAX, '0);
    send_item(SMP_MIN, '0);
    // smallest steps in both directions
    send_item(SMP_MAX, SHIFT_W'(1));
    send_item(SMP_MIN, SHIFT_W'(-1));
    // nominal span limits
    send_item(SMP_MAX, SHIFT_W'(12000));
    send_item(SMP_MIN, SHIFT_W'(-12000));
    // beyond the nominal span, phase wraps
    send_item(SMP_MAX, SHIFT_MAX);
    send_item(SMP_MIN, SHIFT_MIN);
    send_item('0, SHIFT_W'(5));
    send_item(SMP_W'(-1), '0);
    // full-scale square wave at the nominal maximum shift
    for (k = 0; k < 12; k++)
      send_item((k % 2) ? SMP_MIN : SMP_MAX, SHIFT_W'(12000));

    run_random(PHASE_ITEMS);

    // Config sweep, each write with the shifter idle.
    drain_results();
    write_reg(ADDR_PHASE_SCALE, '1);
    run_random(PHASE_ITEMS);

    drain_results();
    write_reg(ADDR_PHASE_SCALE, '0);  // oscillator frozen
    run_random(PHASE_ITEMS);

    drain_results();
    write_reg(ADDR_PHASE_SCALE, CFG_DW'(1));
    run_random(PHASE_ITEMS);

    // write to an unmapped slot must not disturb phase_scale
    drain_results();
    write_reg(ADDR_UNMAPPED, CFG_DW'($urandom()));
    run_random(PHASE_ITEMS);

    drain_results();
    write_reg(ADDR_PHASE_SCALE, CFG_DW'($urandom()));
    run_random(PHASE_ITEMS);

    drain_results();
    write_reg(ADDR_PHASE_SCALE, PHASE_SCALE_RESET);
    run_random(PHASE_ITEMS);

    drain_results();
    // catch any stray late result
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
src/hfs_pkg.sv
src/hfs_ram.sv
src/hfs_sine_rom.sv
src/hfs_core.sv
src/hilbert_frequency_shifter.sv
tb/sv/hfs_shift_checker.sv
tb/sv/tb_hilbert_frequency_shifter.sv
